// ===== rtl/yuyv2bgr_pkg.sv =====
`timescale 1ns / 1ps

package yuyv2bgr_pkg;

    localparam int PIX_W  = 8;
    localparam int COEF_W = 13;
    localparam int DIFF_W = 9;
    localparam int PROD_W = COEF_W + DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int TOT_W  = SUM_W + 1;
    localparam int FRAC_W = 11;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_RED_V   = 2'd0;
    localparam logic [1:0] REG_GREEN_U = 2'd1;
    localparam logic [1:0] REG_GREEN_V = 2'd2;
    localparam logic [1:0] REG_BLUE_U  = 2'd3;

    localparam logic signed [COEF_W-1:0] RST_RED_V   = 13'sd1437;
    localparam logic signed [COEF_W-1:0] RST_GREEN_U = -13'sd352;
    localparam logic signed [COEF_W-1:0] RST_GREEN_V = -13'sd731;
    localparam logic signed [COEF_W-1:0] RST_BLUE_U  = 13'sd1812;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [TOT_W-1:0]  tot_t;

    // chroma offset from mid-scale, doubled: 2*c - 255
    function automatic diff_t chroma_diff(input pix_t c);
        logic signed [DIFF_W:0] d;
        begin
            d = $signed({1'b0, c, 1'b0}) - $signed(10'sd255);
            return d[DIFF_W-1:0];
        end
    endfunction

    // luma*2048 + numerator, truncate toward zero, clamp to 0..255
    function automatic pix_t combine(input pix_t y, input sum_t num);
        tot_t total;
        begin
            total = $signed({{(TOT_W-PIX_W-FRAC_W){1'b0}}, y, {FRAC_W{1'b0}}})
                  + $signed({num[SUM_W-1], num});
            if (total[TOT_W-1])
                return '0;
            else if (total[TOT_W-2:FRAC_W+PIX_W] != '0)
                return '1;
            else
                return total[FRAC_W+PIX_W-1:FRAC_W];
        end
    endfunction

endpackage

// ===== rtl/yuyv_to_bgr_converter.sv =====
`timescale 1ns / 1ps

// YUYV to BGR converter. Each input item is one macropixel (two lumas sharing
// one U and one V) and gives one output item holding two BGR pixels, clamped
// to 0..255; tlast carries the end-of-frame marker through unchanged. A new
// item is taken every cycle unless the output is stalled with the pipeline full;
// items pass through four register stages (chroma offset, coefficient multiply,
// green sum, luma add and clamp) to m_tvalid, the first loaded at acceptance.
// Each stage holds its item while the next is full and cannot advance, so the
// pipeline fills its bubbles under back-pressure. Coefficients are signed
// 13-bit, scaled by 1024, at byte addresses 0 (red/V), 4 (green/U), 8 (green/V),
// 12 (blue/U), and should be written only while no item is in flight.
module yuyv_to_bgr_converter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // luma_first, chroma_u, luma_second, chroma_v
    input  logic [31:0]                       s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // blue_first, green_first, red_first, blue_second, green_second, red_second
    output logic [47:0]                       m_tdata,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [yuyv2bgr_pkg::ADDR_W-1:0]   paddr,
    input  logic [yuyv2bgr_pkg::DATA_W-1:0]   pwdata,
    output logic [yuyv2bgr_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    import yuyv2bgr_pkg::*;

    coef_t coef_red_v_reg, coef_green_u_reg, coef_green_v_reg, coef_blue_u_reg;
    logic  cfg_wr;
    coef_t cfg_rd;

    logic  v1_reg, v2_reg, v3_reg, vo_reg;
    logic  rdy1, rdy2, rdy3;

    pix_t  y1_s1_reg, y2_s1_reg;
    diff_t du_s1_reg, dv_s1_reg;
    logic  fe_s1_reg;

    pix_t  y1_s2_reg, y2_s2_reg;
    prod_t pb_s2_reg, pgu_s2_reg, pgv_s2_reg, pr_s2_reg;
    logic  fe_s2_reg;

    pix_t  y1_s3_reg, y2_s3_reg;
    sum_t  nb_s3_reg, ng_s3_reg, nr_s3_reg;
    logic  fe_s3_reg;

    logic [47:0] tdata_reg, tdata_next;
    logic        tlast_reg;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_red_v_reg   <= RST_RED_V;
            coef_green_u_reg <= RST_GREEN_U;
            coef_green_v_reg <= RST_GREEN_V;
            coef_blue_u_reg  <= RST_BLUE_U;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_RED_V:   coef_red_v_reg   <= pwdata[COEF_W-1:0];
                REG_GREEN_U: coef_green_u_reg <= pwdata[COEF_W-1:0];
                REG_GREEN_V: coef_green_v_reg <= pwdata[COEF_W-1:0];
                REG_BLUE_U:  coef_blue_u_reg  <= pwdata[COEF_W-1:0];
                default:     coef_red_v_reg   <= coef_red_v_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RED_V:   cfg_rd = coef_red_v_reg;
            REG_GREEN_U: cfg_rd = coef_green_u_reg;
            REG_GREEN_V: cfg_rd = coef_green_v_reg;
            REG_BLUE_U:  cfg_rd = coef_blue_u_reg;
            default:     cfg_rd = '0;
        endcase
    end

    assign prdata = {{(DATA_W-COEF_W){cfg_rd[COEF_W-1]}}, cfg_rd};

    // stage handshake
    assign rdy3     = !vo_reg || m_tready;
    assign rdy2     = !v3_reg || rdy3;
    assign rdy1     = !v2_reg || rdy2;
    assign s_tready = !v1_reg || rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                v1_reg <= s_tvalid;
            if (rdy1)
                v2_reg <= v1_reg;
            if (rdy2)
                v3_reg <= v2_reg;
            if (rdy3)
                vo_reg <= v3_reg;
        end
    end

    // stage 1: chroma offsets
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            y1_s1_reg <= s_tdata[7:0];
            du_s1_reg <= chroma_diff(s_tdata[15:8]);
            y2_s1_reg <= s_tdata[23:16];
            dv_s1_reg <= chroma_diff(s_tdata[31:24]);
            fe_s1_reg <= s_tlast;
        end
    end

    // stage 2: coefficient products
    always_ff @(posedge clk)
    begin
        if (rdy1 && v1_reg)
        begin
            y1_s2_reg  <= y1_s1_reg;
            y2_s2_reg  <= y2_s1_reg;
            fe_s2_reg  <= fe_s1_reg;
            pb_s2_reg  <= PROD_W'(coef_blue_u_reg * du_s1_reg);
            pgu_s2_reg <= PROD_W'(coef_green_u_reg * du_s1_reg);
            pgv_s2_reg <= PROD_W'(coef_green_v_reg * dv_s1_reg);
            pr_s2_reg  <= PROD_W'(coef_red_v_reg * dv_s1_reg);
        end
    end

    // stage 3: chroma numerators
    always_ff @(posedge clk)
    begin
        if (rdy2 && v2_reg)
        begin
            y1_s3_reg <= y1_s2_reg;
            y2_s3_reg <= y2_s2_reg;
            fe_s3_reg <= fe_s2_reg;
            nb_s3_reg <= {pb_s2_reg[PROD_W-1], pb_s2_reg};
            ng_s3_reg <= {pgu_s2_reg[PROD_W-1], pgu_s2_reg}
                       + {pgv_s2_reg[PROD_W-1], pgv_s2_reg};
            nr_s3_reg <= {pr_s2_reg[PROD_W-1], pr_s2_reg};
        end
    end

    // stage 4: luma add, truncate and clamp
    always_comb
    begin
        tdata_next[7:0]   = combine(y1_s3_reg, nb_s3_reg);
        tdata_next[15:8]  = combine(y1_s3_reg, ng_s3_reg);
        tdata_next[23:16] = combine(y1_s3_reg, nr_s3_reg);
        tdata_next[31:24] = combine(y2_s3_reg, nb_s3_reg);
        tdata_next[39:32] = combine(y2_s3_reg, ng_s3_reg);
        tdata_next[47:40] = combine(y2_s3_reg, nr_s3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v3_reg)
        begin
            tdata_reg <= tdata_next;
            tlast_reg <= fe_s3_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

`ifndef ASSERT_OFF
    a_stall_only_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output is free");

    a_last_stage_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && rdy3) |=> m_tvalid)
        else $error("item lost between last stage and output");

    a_full_pipe_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> ($countones({v1_reg, v2_reg, v3_reg, vo_reg}) == 4))
        else $error("input stalled with a bubble in the pipeline");
`endif

endmodule
